@@ sv/trim_pkg.sv @@
package trim_pkg;

  localparam int unsigned VW = 24;
  localparam logic [VW-1:0] VMAX = '1;

  // register stages from the input beat to the last pipeline stage
  localparam int unsigned PIPE_DEPTH = 109;

  localparam logic OP_SIDES = 1'b0;
  localparam logic OP_VERTS = 1'b1;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;
  // unused code, treated as side c
  localparam logic [1:0] SEL_NONE = 2'd3;

  typedef struct packed {
    logic [51:0] rem;
    logic [49:0] root;
  } sq_t;

  typedef struct packed {
    logic [49:0] rem;
    logic        qbit;
  } dv_t;

  // one restoring square root step, two radicand bits in
  function automatic sq_t sqrt_step(input logic [51:0] rem, input logic [49:0] root,
                                    input logic [1:0] pair);
    logic [53:0] cand;
    logic [53:0] trial;
    sq_t         res;
    cand  = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (cand >= trial) begin
      res.rem  = 52'(cand - trial);
      res.root = {root[48:0], 1'b1};
    end else begin
      res.rem  = cand[51:0];
      res.root = {root[48:0], 1'b0};
    end
    return res;
  endfunction

  // one restoring division step, one dividend bit in
  function automatic dv_t div_step(input logic [49:0] rem, input logic [49:0] dvs,
                                   input logic nbit);
    logic [50:0] cand;
    dv_t         res;
    cand = {rem, nbit};
    if (cand >= {1'b0, dvs}) begin
      res.rem  = 50'(cand - {1'b0, dvs});
      res.qbit = 1'b1;
    end else begin
      res.rem  = cand[49:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ sv/triangle_measures.sv @@
// triangle measures: median and midline to a chosen side, inradius and circumradius
// input channel s_axis: one beat per triangle, given by three sides (op 0) or by
// three vertices (op 1); output channel m_axis: one beat per input beat, in order
// all values Q16.8, unsigned but for signed vertex coordinates; square roots and
// divisions truncate; an accepted beat passes every pipeline stage and then the
// output register; the depth is set by the chained square root and division step
// stages of the circumradius path (vertex distance root, area root, quotient)
// throughput: a beat per cycle while s_axis_tready is high, one triangle per stage
// reset clears every valid bit, the output valid too; data registers, the output
// data register among them, keep whatever they hold
// when the receiver stalls, the result waits in the output register and the
// pipeline keeps accepting beats until its last stage is occupied, then
// s_axis_tready drops; nothing is lost or repeated
module triangle_measures (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // length_a, length_b, length_c, first_px, first_py, second_px, second_py,
  // third_px, third_py
  input  logic [215:0] s_axis_tdata,
  // op, side_select
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // median_len, midline_len, inner_radius, outer_radius
  output logic [95:0]  m_axis_tdata,
  // invalid, overflow
  output logic [1:0]   m_axis_tuser
);

  typedef struct packed {
    logic        op;
    logic [1:0]  sel;
    logic [23:0] la;
    logic [23:0] lb;
    logic [23:0] lc;
  } pre_t;

  typedef struct packed {
    logic        bad;
    logic        op;
    logic        ovf;
    logic [23:0] mid;
  } side_t;

  logic                                en;
  logic [trim_pkg::PIPE_DEPTH-1:0]     vld_q;
  logic                                out_vld_q;
  logic [95:0]                         out_data_q;
  logic [1:0]                          out_user_q;

  assign en = ~vld_q[trim_pkg::PIPE_DEPTH-1] | ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[trim_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------- vertex distances
  logic [24:0] mx_d [3];
  logic [24:0] my_d [3];
  logic [24:0] mx_q [3];
  logic [24:0] my_q [3];
  logic [49:0] sqx_q [3];
  logic [49:0] sqy_q [3];
  logic [49:0] n3_q [3];
  pre_t        pre_q [3];
  pre_t        pre_d;

  assign pre_d = '{op: s_axis_tuser[0], sel: s_axis_tuser[2:1], la: s_axis_tdata[23:0],
                   lb: s_axis_tdata[47:24], lc: s_axis_tdata[71:48]};

  // side a is P1P2, b is P2P3, c is P1P3
  for (genvar gj = 0; gj < 3; gj++) begin : g_diff
    localparam int unsigned VP = (gj == 1) ? 1 : 0;
    localparam int unsigned VQ = (gj == 0) ? 1 : 2;
    logic [24:0] dx;
    logic [24:0] dy;
    assign dx = {s_axis_tdata[72+48*VP+23], s_axis_tdata[72+48*VP +: 24]}
              - {s_axis_tdata[72+48*VQ+23], s_axis_tdata[72+48*VQ +: 24]};
    assign dy = {s_axis_tdata[96+48*VP+23], s_axis_tdata[96+48*VP +: 24]}
              - {s_axis_tdata[96+48*VQ+23], s_axis_tdata[96+48*VQ +: 24]};
    assign mx_d[gj] = dx[24] ? 25'(-dx) : dx;
    assign my_d[gj] = dy[24] ? 25'(-dy) : dy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q[0] <= pre_d;
      pre_q[1] <= pre_q[0];
      pre_q[2] <= pre_q[1];
      for (int j = 0; j < 3; j++) begin
        mx_q[j]  <= mx_d[j];
        my_q[j]  <= my_d[j];
        sqx_q[j] <= 50'(mx_q[j]) * 50'(mx_q[j]);
        sqy_q[j] <= 50'(my_q[j]) * 50'(my_q[j]);
        n3_q[j]  <= sqx_q[j] + sqy_q[j];
      end
    end
  end

  logic [26:0] drem_q  [3][25];
  logic [24:0] droot_q [3][25];
  logic [49:0] dn_q    [3][24];
  pre_t        pa_q    [25];

  for (genvar gj = 0; gj < 3; gj++) begin : g_dsq
    for (genvar gk = 0; gk < 25; gk++) begin : g_step
      logic [26:0]     rem_in;
      logic [24:0]     root_in;
      logic [49:0]     n_in;
      trim_pkg::sq_t   st;
      if (gk == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign n_in    = n3_q[gj];
      end else begin : g_next
        assign rem_in  = drem_q[gj][gk-1];
        assign root_in = droot_q[gj][gk-1];
        assign n_in    = dn_q[gj][gk-1];
      end
      assign st = trim_pkg::sqrt_step(52'(rem_in), 50'(root_in), n_in[49:48]);
      always_ff @(posedge clk_i) begin
        if (en) begin
          drem_q[gj][gk]  <= st.rem[26:0];
          droot_q[gj][gk] <= st.root[24:0];
        end
      end
      if (gk < 24) begin : g_n
        always_ff @(posedge clk_i) begin
          if (en) dn_q[gj][gk] <= {n_in[47:0], 2'b00};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= pre_q[2];
      for (int k = 1; k < 25; k++) pa_q[k] <= pa_q[k-1];
    end
  end

  // ---------------------------------------------------------------- side choice
  logic [23:0] a_d, b_d, c_d, x_d, y_d, z_d;
  logic        dovf_d;

  always_comb begin
    logic [23:0] dlen [3];
    logic        any_sat;
    pre_t        pl;
    pl      = pa_q[24];
    any_sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      dlen[j] = droot_q[j][24][24] ? trim_pkg::VMAX : droot_q[j][24][23:0];
      any_sat = any_sat | droot_q[j][24][24];
    end
    if (pl.op == trim_pkg::OP_VERTS) begin
      a_d = dlen[0];
      b_d = dlen[1];
      c_d = dlen[2];
    end else begin
      a_d = pl.la;
      b_d = pl.lb;
      c_d = pl.lc;
    end
    dovf_d = (pl.op == trim_pkg::OP_VERTS) & any_sat;
    unique case (pl.sel)
      trim_pkg::SEL_A: begin
        x_d = a_d; y_d = b_d; z_d = c_d;
      end
      trim_pkg::SEL_B: begin
        x_d = b_d; y_d = a_d; z_d = c_d;
      end
      default: begin
        x_d = c_d; y_d = a_d; z_d = b_d;
      end
    endcase
  end

  logic [23:0] a0_q, b0_q, c0_q, x0_q, y0_q, z0_q;
  logic        op0_q, ovf0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q   <= a_d;
      b0_q   <= b_d;
      c0_q   <= c_d;
      x0_q   <= x_d;
      y0_q   <= y_d;
      z0_q   <= z_d;
      op0_q  <= pa_q[24].op;
      ovf0_q <= dovf_d;
    end
  end

  // ---------------------------------------------------------------- perimeter terms, squares
  logic [25:0] p_d, u_d, v_d, w_d;
  logic        bad_d;

  assign p_d   = 26'(a0_q) + 26'(b0_q) + 26'(c0_q);
  assign u_d   = 26'(b0_q) + 26'(c0_q) - 26'(a0_q);
  assign v_d   = 26'(a0_q) + 26'(c0_q) - 26'(b0_q);
  assign w_d   = 26'(a0_q) + 26'(b0_q) - 26'(c0_q);
  assign bad_d = u_d[25] | (u_d == '0) | v_d[25] | (v_d == '0) | w_d[25] | (w_d == '0);

  side_t       side1_q;
  logic [25:0] p1_q;
  logic [24:0] u1_q, v1_q, w1_q;
  logic [47:0] yy1_q, zz1_q, xx1_q, ab1_q;
  logic [23:0] c1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= '{bad: bad_d, op: op0_q, ovf: ovf0_q, mid: {1'b0, x0_q[23:1]}};
      p1_q    <= p_d;
      u1_q    <= u_d[24:0];
      v1_q    <= v_d[24:0];
      w1_q    <= w_d[24:0];
      yy1_q   <= 48'(y0_q) * 48'(y0_q);
      zz1_q   <= 48'(z0_q) * 48'(z0_q);
      xx1_q   <= 48'(x0_q) * 48'(x0_q);
      ab1_q   <= 48'(a0_q) * 48'(b0_q);
      c1_q    <= c0_q;
    end
  end

  // ---------------------------------------------------------------- median radicand, partials
  logic [48:0] yz_d;
  logic [49:0] t_d;
  logic [49:0] q_d;

  assign yz_d = 49'(yy1_q) + 49'(zz1_q);
  assign t_d  = {yz_d, 1'b0};
  assign q_d  = (t_d >= 50'(xx1_q)) ? (t_d - 50'(xx1_q)) : '0;

  side_t       side2_q;
  logic [49:0] q2_q, uv2_q;
  logic [24:0] w2_q;
  logic [47:0] abp0_2_q, abp1_2_q;
  logic [25:0] p2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q  <= side1_q;
      q2_q     <= q_d;
      uv2_q    <= 50'(u1_q) * 50'(v1_q);
      w2_q     <= w1_q;
      abp0_2_q <= 48'(ab1_q[23:0]) * 48'(c1_q);
      abp1_2_q <= 48'(ab1_q[47:24]) * 48'(c1_q);
      p2_q     <= p1_q;
    end
  end

  logic [49:0] uvp0_3_q, uvp1_3_q;
  logic [71:0] abc3_q, abc4_q, abc5_q, abc6_q;
  logic [25:0] p3_q, p4_q;
  logic [74:0] uvw4_q;
  logic [50:0] pp0_5_q, pp1_5_q, pp2_5_q;
  logic [99:0] pu6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      uvp0_3_q <= 50'(uv2_q[24:0]) * 50'(w2_q);
      uvp1_3_q <= 50'(uv2_q[49:25]) * 50'(w2_q);
      abc3_q   <= 72'(abp0_2_q) + {abp1_2_q, 24'b0};
      p3_q     <= p2_q;
      uvw4_q   <= 75'(uvp0_3_q) + {uvp1_3_q, 25'b0};
      abc4_q   <= abc3_q;
      p4_q     <= p3_q;
      pp0_5_q  <= 51'(uvw4_q[24:0]) * 51'(p4_q);
      pp1_5_q  <= 51'(uvw4_q[49:25]) * 51'(p4_q);
      pp2_5_q  <= 51'(uvw4_q[74:50]) * 51'(p4_q);
      abc5_q   <= abc4_q;
      pu6_q    <= 100'(pp0_5_q) + 100'({pp1_5_q, 25'b0}) + 100'({pp2_5_q, 50'b0});
      abc6_q   <= abc5_q;
    end
  end

  // ---------------------------------------------------------------- median root
  logic [26:0] mrem_q  [25];
  logic [24:0] mroot_q [25];
  logic [49:0] mn_q    [24];

  for (genvar gk = 0; gk < 25; gk++) begin : g_msq
    logic [26:0]   rem_in;
    logic [24:0]   root_in;
    logic [49:0]   n_in;
    trim_pkg::sq_t st;
    if (gk == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = q2_q;
    end else begin : g_next
      assign rem_in  = mrem_q[gk-1];
      assign root_in = mroot_q[gk-1];
      assign n_in    = mn_q[gk-1];
    end
    assign st = trim_pkg::sqrt_step(52'(rem_in), 50'(root_in), n_in[49:48]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        mrem_q[gk]  <= st.rem[26:0];
        mroot_q[gk] <= st.root[24:0];
      end
    end
    if (gk < 24) begin : g_n
      always_ff @(posedge clk_i) begin
        if (en) mn_q[gk] <= {n_in[47:0], 2'b00};
      end
    end
  end

  // ---------------------------------------------------------------- inradius quotient
  // the quotient of a valid triangle stays below 2^46
  logic [27:0] rrem_q [46];
  logic [27:0] rdv_q  [45];
  logic [45:0] rn_q   [45];
  logic [45:0] rq_q   [46];

  for (genvar gk = 0; gk < 46; gk++) begin : g_rdiv
    logic [27:0]   rem_in;
    logic [27:0]   d_in;
    logic [45:0]   n_in;
    logic [45:0]   q_in;
    trim_pkg::dv_t st;
    if (gk == 0) begin : g_first
      assign rem_in = uvw4_q[73:46];
      assign d_in   = {p4_q, 2'b00};
      assign n_in   = uvw4_q[45:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rrem_q[gk-1];
      assign d_in   = rdv_q[gk-1];
      assign n_in   = rn_q[gk-1];
      assign q_in   = rq_q[gk-1];
    end
    assign st = trim_pkg::div_step(50'(rem_in), 50'(d_in), n_in[45]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        rrem_q[gk] <= st.rem[27:0];
        rq_q[gk]   <= {q_in[44:0], st.qbit};
      end
    end
    if (gk < 45) begin : g_n
      always_ff @(posedge clk_i) begin
        if (en) begin
          rdv_q[gk] <= d_in;
          rn_q[gk]  <= {n_in[44:0], 1'b0};
        end
      end
    end
  end

  logic [24:0] rsrem_q  [23];
  logic [22:0] rsroot_q [23];
  logic [45:0] rsn_q    [22];

  for (genvar gk = 0; gk < 23; gk++) begin : g_rsq
    logic [24:0]   rem_in;
    logic [22:0]   root_in;
    logic [45:0]   n_in;
    trim_pkg::sq_t st;
    if (gk == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = rq_q[45];
    end else begin : g_next
      assign rem_in  = rsrem_q[gk-1];
      assign root_in = rsroot_q[gk-1];
      assign n_in    = rsn_q[gk-1];
    end
    assign st = trim_pkg::sqrt_step(52'(rem_in), 50'(root_in), n_in[45:44]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        rsrem_q[gk]  <= st.rem[24:0];
        rsroot_q[gk] <= st.root[22:0];
      end
    end
    if (gk < 22) begin : g_n
      always_ff @(posedge clk_i) begin
        if (en) rsn_q[gk] <= {n_in[43:0], 2'b00};
      end
    end
  end

  // ---------------------------------------------------------------- four times the area
  logic [51:0] arem_q  [50];
  logic [49:0] aroot_q [50];
  logic [99:0] an_q    [49];
  logic [71:0] aabc_q  [50];

  for (genvar gk = 0; gk < 50; gk++) begin : g_asq
    logic [51:0]   rem_in;
    logic [49:0]   root_in;
    logic [99:0]   n_in;
    logic [71:0]   abc_in;
    trim_pkg::sq_t st;
    if (gk == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = pu6_q;
      assign abc_in  = abc6_q;
    end else begin : g_next
      assign rem_in  = arem_q[gk-1];
      assign root_in = aroot_q[gk-1];
      assign n_in    = an_q[gk-1];
      assign abc_in  = aabc_q[gk-1];
    end
    assign st = trim_pkg::sqrt_step(rem_in, root_in, n_in[99:98]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        arem_q[gk]  <= st.rem;
        aroot_q[gk] <= st.root;
        aabc_q[gk]  <= abc_in;
      end
    end
    if (gk < 49) begin : g_n
      always_ff @(posedge clk_i) begin
        if (en) an_q[gk] <= {n_in[97:0], 2'b00};
      end
    end
  end

  // ---------------------------------------------------------------- circumradius quotient
  // abc >> 24 at or above the divisor means the quotient does not fit
  logic [49:0] crem_q [24];
  logic [49:0] cdv_q  [23];
  logic [23:0] cn_q   [23];
  logic [23:0] cq_q   [24];
  logic        csat_q [24];

  for (genvar gk = 0; gk < 24; gk++) begin : g_cdiv
    logic [49:0]   rem_in;
    logic [49:0]   d_in;
    logic [23:0]   n_in;
    logic [23:0]   q_in;
    logic          sat_in;
    trim_pkg::dv_t st;
    if (gk == 0) begin : g_first
      assign rem_in = 50'(aabc_q[49][71:24]);
      assign d_in   = aroot_q[49];
      assign n_in   = aabc_q[49][23:0];
      assign q_in   = '0;
      assign sat_in = (50'(aabc_q[49][71:24]) >= aroot_q[49]);
    end else begin : g_next
      assign rem_in = crem_q[gk-1];
      assign d_in   = cdv_q[gk-1];
      assign n_in   = cn_q[gk-1];
      assign q_in   = cq_q[gk-1];
      assign sat_in = csat_q[gk-1];
    end
    assign st = trim_pkg::div_step(rem_in, d_in, n_in[23]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        crem_q[gk] <= st.rem;
        cq_q[gk]   <= {q_in[22:0], st.qbit};
        csat_q[gk] <= sat_in;
      end
    end
    if (gk < 23) begin : g_n
      always_ff @(posedge clk_i) begin
        if (en) begin
          cdv_q[gk] <= d_in;
          cn_q[gk]  <= {n_in[22:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- alignment
  side_t       sdl_q [78];
  logic [24:0] mdl_q [53];
  logic [22:0] rid_q [7];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdl_q[0] <= side2_q;
      for (int i = 1; i < 78; i++) sdl_q[i] <= sdl_q[i-1];
      mdl_q[0] <= mroot_q[24];
      for (int i = 1; i < 53; i++) mdl_q[i] <= mdl_q[i-1];
      rid_q[0] <= rsroot_q[22];
      for (int i = 1; i < 7; i++) rid_q[i] <= rid_q[i-1];
    end
  end

  // ---------------------------------------------------------------- output register
  side_t       sf;
  logic [24:0] mr;
  logic [23:0] med_r, rin_r, rout_r;
  logic        ovf_r;
  logic        out_load;

  assign sf       = sdl_q[77];
  assign mr       = mdl_q[52];
  assign med_r    = sf.bad ? '0 : mr[24:1];
  assign rin_r    = sf.bad ? '0 : {1'b0, rid_q[6]};
  assign rout_r   = sf.bad ? '0 : (csat_q[23] ? trim_pkg::VMAX : cq_q[23]);
  assign ovf_r    = sf.ovf | (~sf.bad & (((sf.op == trim_pkg::OP_VERTS) & mr[24])
                                         | csat_q[23]));
  assign out_load = ~out_vld_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= vld_q[trim_pkg::PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && vld_q[trim_pkg::PIPE_DEPTH-1]) begin
      out_data_q <= {rout_r, rin_r, sf.mid, med_r};
      out_user_q <= {ovf_r, sf.bad};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---------------------------------------------------------------- checks
  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[trim_pkg::PIPE_DEPTH-1] && out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("pipeline accepts a beat while its last stage cannot drain");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[23:0] == '0 && m_axis_tdata[71:48] == '0 && m_axis_tdata[95:72] == '0))
    else $error("invalid triangle with nonzero median or radius");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted beat missing from first stage");

endmodule

@@ tb/sv/tb_triangle_checker.sv @@
module tb_triangle_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [215:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count_o,
  output int           outstanding_o,
  output int           invalid_seen_o,
  output int           overflow_seen_o
);

  typedef struct {
    logic [trim_pkg::VW-1:0] median;
    logic [trim_pkg::VW-1:0] midline;
    logic [trim_pkg::VW-1:0] inner;
    logic [trim_pkg::VW-1:0] outer;
    logic                    invalid;
    logic                    overflow;
  } measures_t;

  measures_t expected_measures[$];

  function automatic logic [159:0] int_sqrt(input logic [159:0] n);
    logic [161:0] rem;
    logic [161:0] trial;
    logic [159:0] root;
    rem  = '0;
    root = '0;
    for (int i = 79; i >= 0; i--) begin
      rem   = {rem[159:0], n[2*i+1], n[2*i]};
      trial = {root, 2'b01};
      root  = {root[158:0], 1'b0};
      if (rem >= trial) begin
        rem     = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  function automatic logic [trim_pkg::VW-1:0] clamp(input logic [159:0] v, inout logic ovf);
    if (v > 160'(trim_pkg::VMAX)) begin
      ovf = 1'b1;
      return trim_pkg::VMAX;
    end
    return v[trim_pkg::VW-1:0];
  endfunction

  function automatic logic [63:0] vertex_dist(input logic [trim_pkg::VW-1:0] px,
                                              input logic [trim_pkg::VW-1:0] py,
                                              input logic [trim_pkg::VW-1:0] qx,
                                              input logic [trim_pkg::VW-1:0] qy,
                                              inout logic ovf);
    longint dx, dy;
    logic [159:0] sq;
    dx = longint'($signed(px)) - longint'($signed(qx));
    dy = longint'($signed(py)) - longint'($signed(qy));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = 160'(dx) * 160'(dx) + 160'(dy) * 160'(dy);
    return 64'(clamp(int_sqrt(sq), ovf));
  endfunction

  function automatic measures_t measure_triangle(input logic [215:0] d, input logic [2:0] usr);
    measures_t    r;
    logic         ovf;
    logic [63:0]  a, b, c, x, y, z;
    longint       u, v, w;
    logic [159:0] t, xx, q, uvw, area4, abc, root, half, per;
    ovf = 1'b0;
    if (usr[0] == trim_pkg::OP_SIDES) begin
      a = 64'(d[23:0]);
      b = 64'(d[47:24]);
      c = 64'(d[71:48]);
    end else begin
      a = vertex_dist(d[95:72], d[119:96], d[143:120], d[167:144], ovf);
      b = vertex_dist(d[143:120], d[167:144], d[191:168], d[215:192], ovf);
      c = vertex_dist(d[95:72], d[119:96], d[191:168], d[215:192], ovf);
    end
    case (usr[2:1])
      trim_pkg::SEL_A: begin x = a; y = b; z = c; end
      trim_pkg::SEL_B: begin x = b; y = a; z = c; end
      default:         begin x = c; y = a; z = b; end
    endcase
    u = longint'(b + c) - longint'(a);
    v = longint'(a + c) - longint'(b);
    w = longint'(a + b) - longint'(c);
    r.invalid = (u <= 0 || v <= 0 || w <= 0);
    r.midline = trim_pkg::VW'(x >> 1);
    r.median  = '0;
    r.inner   = '0;
    r.outer   = '0;
    if (!r.invalid) begin
      per   = 160'(a + b + c);
      t     = (160'(y) * 160'(y) + 160'(z) * 160'(z)) << 1;
      xx    = 160'(x) * 160'(x);
      q     = (t >= xx) ? t - xx : '0;
      uvw   = 160'(u) * 160'(v) * 160'(w);
      area4 = int_sqrt(uvw * per);
      abc   = 160'(a) * 160'(b) * 160'(c);
      root  = int_sqrt(q);
      if (root > 160'(trim_pkg::VMAX)) begin
        // halve the full root; only vertex input or a still-too-large half flags it
        half = root >> 1;
        if (half > 160'(trim_pkg::VMAX) || usr[0] == trim_pkg::OP_VERTS) ovf = 1'b1;
        r.median = (half > 160'(trim_pkg::VMAX)) ? trim_pkg::VMAX
                                                 : half[trim_pkg::VW-1:0];
      end else begin
        r.median = root[trim_pkg::VW:1];
      end
      r.inner = clamp(int_sqrt(uvw / (per << 2)), ovf);
      r.outer = clamp(abc / area4, ovf);
    end
    r.overflow = ovf;
    return r;
  endfunction

  assign outstanding_o = expected_measures.size();

  always @(posedge clk_i or negedge rst_ni) begin
    measures_t e;
    if (!rst_ni) begin
      fail_count_o    <= 0;
      invalid_seen_o  <= 0;
      overflow_seen_o <= 0;
      expected_measures.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_measures.size() == 0) begin
          $error("result beat with no triangle outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_measures.pop_front();
          if (e.invalid) invalid_seen_o <= invalid_seen_o + 1;
          if (e.overflow) overflow_seen_o <= overflow_seen_o + 1;
          if (m_axis_tdata[23:0] !== e.median ||
              m_axis_tdata[47:24] !== e.midline ||
              m_axis_tdata[71:48] !== e.inner ||
              m_axis_tdata[95:72] !== e.outer ||
              m_axis_tuser[0] !== e.invalid ||
              m_axis_tuser[1] !== e.overflow)
            fail_count_o <= fail_count_o + 1;
          if (m_axis_tdata[23:0] !== e.median)
            $error("median_len expected %h got %h", e.median, m_axis_tdata[23:0]);
          if (m_axis_tdata[47:24] !== e.midline)
            $error("midline_len expected %h got %h", e.midline, m_axis_tdata[47:24]);
          if (m_axis_tdata[71:48] !== e.inner)
            $error("inner_radius expected %h got %h", e.inner, m_axis_tdata[71:48]);
          if (m_axis_tdata[95:72] !== e.outer)
            $error("outer_radius expected %h got %h", e.outer, m_axis_tdata[95:72]);
          if (m_axis_tuser[0] !== e.invalid)
            $error("invalid expected %b got %b", e.invalid, m_axis_tuser[0]);
          if (m_axis_tuser[1] !== e.overflow)
            $error("overflow expected %b got %b", e.overflow, m_axis_tuser[1]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_measures.push_back(measure_triangle(s_axis_tdata, s_axis_tuser));
    end
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int fail_count, outstanding, invalid_seen, overflow_seen;
  int cycles = 0;
  int sides_sent = 0, verts_sent = 0;
  bit no_idle = 1'b0;

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  triangle_measures dut (.*);

  tb_triangle_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .outstanding_o(outstanding),
    .invalid_seen_o(invalid_seen), .overflow_seen_o(overflow_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall before each result beat, none while no_idle is set
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_triangle(input logic op, input logic [1:0] sel,
                               input logic [215:0] fields);
    int gap;
    s_axis_tuser  = {sel, op};
    s_axis_tdata  = fields;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == trim_pkg::OP_SIDES) sides_sent++; else verts_sent++;
    @(negedge clk_i);
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic logic [215:0] sides(input logic [23:0] a, input logic [23:0] b,
                                         input logic [23:0] c);
    return {144'($urandom), c, b, a};
  endfunction

  function automatic logic [215:0] verts(input logic [23:0] x1, input logic [23:0] y1,
                                         input logic [23:0] x2, input logic [23:0] y2,
                                         input logic [23:0] x3, input logic [23:0] y3);
    return {y3, x3, y2, x2, y1, x1, 24'($urandom), 24'($urandom), 24'($urandom)};
  endfunction

  function automatic logic [23:0] rand_len();
    int unsigned w;
    w = $urandom_range(1, 24);
    return 24'($urandom & ((32'd1 << w) - 1));
  endfunction

  function automatic logic [23:0] rand_coord();
    int unsigned w;
    w = $urandom_range(1, 24);
    return 24'($signed(24'($urandom & ((32'd1 << w) - 1))) >>> (24 - w + $urandom_range(0, 1)))
           ^ ($urandom_range(0, 3) == 0 ? 24'($urandom) : 24'h0);
  endfunction

  initial begin
    logic [23:0] a, b, c, lo, hi, x1, y1, x2, y2, x3, y3;
    logic [1:0]  sel;
    logic        op;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: corners of the value range, every side choice, degenerate shapes
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_A, sides(24'h0, 24'h0, 24'h0));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_B,
                  sides(trim_pkg::VMAX, trim_pkg::VMAX, trim_pkg::VMAX));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_C,
                  sides(trim_pkg::VMAX, trim_pkg::VMAX, 24'h1));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_NONE,
                  sides(24'h1, trim_pkg::VMAX, trim_pkg::VMAX));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_A,
                  sides(24'h1, trim_pkg::VMAX, trim_pkg::VMAX));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_A, sides(24'h500, 24'h300, 24'h200));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_B, sides(24'h300, 24'h900, 24'h400));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_C, sides(24'h300, 24'h400, 24'h500));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_A, sides(24'h1, 24'h1, 24'h1));
    send_triangle(trim_pkg::OP_SIDES, trim_pkg::SEL_B, sides(24'h1, 24'h2, 24'h2));
    send_triangle(trim_pkg::OP_VERTS, trim_pkg::SEL_A,
                  verts(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff,
                        24'h800000, 24'h7fffff));
    send_triangle(trim_pkg::OP_VERTS, trim_pkg::SEL_B,
                  verts(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
                        24'h7fffff, 24'h7fffff));
    send_triangle(trim_pkg::OP_VERTS, trim_pkg::SEL_C,
                  verts(24'h0, 24'h0, 24'h300, 24'h0, 24'h0, 24'h400));
    send_triangle(trim_pkg::OP_VERTS, trim_pkg::SEL_NONE,
                  verts(24'h0, 24'h0, 24'h100, 24'h100, 24'h200, 24'h200));
    send_triangle(trim_pkg::OP_VERTS, trim_pkg::SEL_A,
                  verts(24'h123, 24'h456, 24'h123, 24'h456, 24'h123, 24'h456));
    send_triangle(trim_pkg::OP_VERTS, trim_pkg::SEL_C,
                  verts(24'hffff00, 24'hffff00, 24'h100, 24'hffff00,
                        24'hffff00, 24'h100));
    send_triangle(trim_pkg::OP_VERTS, trim_pkg::SEL_B,
                  verts(24'h800000, 24'h0, 24'h7fffff, 24'h0, 24'h0, 24'h1));

    for (int i = 0; i < 1100; i++) begin
      if (i == 550) begin
        // drain the pipeline completely before resuming
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) @(negedge clk_i);
      end
      if (i % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
      sel = 2'($urandom_range(0, 3));
      op  = 1'($urandom);
      if (op == trim_pkg::OP_SIDES) begin
        a = rand_len();
        b = rand_len();
        case ($urandom_range(0, 9))
          0:       c = rand_len();
          1:       c = 24'(a + b);
          2:       c = $urandom_range(0, 1) ? trim_pkg::VMAX : 24'($urandom);
          default: begin
            lo = (a > b) ? a - b : b - a;
            hi = (25'(a) + b > trim_pkg::VMAX) ? trim_pkg::VMAX : a + b;
            c  = (hi > lo + 1) ? 24'(lo + 1 + ($urandom % (hi - lo - 1))) : a;
          end
        endcase
        send_triangle(op, sel, sides(a, b, c));
      end else begin
        x1 = rand_coord(); y1 = rand_coord();
        x2 = rand_coord(); y2 = rand_coord();
        case ($urandom_range(0, 7))
          0: begin x3 = x1; y3 = y1; end
          1: begin x3 = 24'(x1 + x1 - x2); y3 = 24'(y1 + y1 - y2); end
          default: begin x3 = rand_coord(); y3 = rand_coord(); end
        endcase
        send_triangle(op, sel, verts(x1, y1, x2, y2, x3, y3));
      end
    end
    s_axis_tvalid = 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("checked %0d side-length and %0d vertex triangles, %0d invalid, %0d overflowed",
             sides_sent, verts_sent, invalid_seen, overflow_seen);
    $display("random stalls and gaps on both channels, one full drain midway");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
